>>> hdl/hbsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the HDLC bit stuffing framer.
package hbsf_pkg;

	// Frame delimiter geometry.
	localparam int FLAG_BITS   = 8;
	localparam int FLAG_IDX_W  = $clog2(FLAG_BITS);
	localparam logic [FLAG_BITS-1:0] FLAG_RESET = 8'h7E;

	// Receive side drops the first and the last flag length of each frame.
	localparam int POS_FULL    = 2 * FLAG_BITS;
	localparam int POS_W       = $clog2(POS_FULL + 1);

	// Defaults for the top level parameters.
	localparam int RUN_LIMIT_DEF   = 5;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAG = 1'b1;

	// Operating modes.
	localparam logic MODE_STUFF   = 1'b0;
	localparam logic MODE_DESTUFF = 1'b1;

	// Work descriptor for one accepted item; results go out in field order.
	typedef struct packed {
		logic open_flag;   // opening flag before the data bit
		logic has_data;    // one data bit
		logic data_bit;
		logic stuff_zero;  // inserted zero after a run of ones
		logic close_flag;  // closing flag, last bit ends the frame
		logic marker;      // frame end marker without a bit
	} job_t;

endpackage

>>> hdl/hbsf_front.sv
`timescale 1ns / 1ps
// Front end: accepts input bits, tracks frame and run state, builds job descriptors.
module hbsf_front #(
	parameter int RUN_LIMIT = hbsf_pkg::RUN_LIMIT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode,
	input  logic           mode_wr,
	input  logic           accept,
	input  logic           in_bit,
	input  logic           frame_last,
	output logic           push,
	output hbsf_pkg::job_t push_job
);
	import hbsf_pkg::*;

	localparam int RUN_W = $clog2(RUN_LIMIT + 1);

	logic [RUN_W-1:0]     ones_run_q;
	logic                 in_frame_q;
	logic [FLAG_BITS-1:0] rx_window_q;
	logic [POS_W-1:0]     rx_position_q;
	logic                 skip_next_q;

	logic [RUN_W-1:0]     ones_run_d;
	logic                 in_frame_d;
	logic [FLAG_BITS-1:0] rx_window_d;
	logic [POS_W-1:0]     rx_position_d;
	logic                 skip_next_d;
	logic [RUN_W-1:0]     run_base;
	logic [RUN_W-1:0]     run_inc;
	logic                 evicted;
	job_t                 job;

	always_comb begin
		job           = '0;
		ones_run_d    = ones_run_q;
		in_frame_d    = in_frame_q;
		rx_window_d   = rx_window_q;
		rx_position_d = rx_position_q;
		skip_next_d   = skip_next_q;
		evicted       = rx_window_q[FLAG_BITS-1];
		run_base      = ones_run_q;
		run_inc       = '0;
		if (mode == MODE_STUFF) begin
			if (!in_frame_q) begin
				job.open_flag = 1'b1;
				run_base      = '0;
			end
			in_frame_d    = 1'b1;
			run_inc       = run_base + RUN_W'(1);
			job.has_data  = 1'b1;
			job.data_bit  = in_bit;
			ones_run_d    = in_bit ? run_inc : '0;
			if (in_bit && (run_inc >= RUN_W'(RUN_LIMIT))) begin
				job.stuff_zero = 1'b1;
				ones_run_d     = '0;
			end
			if (frame_last) begin
				job.close_flag = 1'b1;
				ones_run_d     = '0;
				in_frame_d     = 1'b0;
				rx_window_d    = '0;
				rx_position_d  = '0;
				skip_next_d    = 1'b0;
			end
		end else begin
			in_frame_d  = 1'b1;
			rx_window_d = {rx_window_q[FLAG_BITS-2:0], in_bit};
			if (rx_position_q >= POS_W'(POS_FULL)) begin
				if (skip_next_q) begin
					// The bit after a full run of ones is a stuffed bit: drop it.
					skip_next_d = 1'b0;
				end else begin
					run_inc      = ones_run_q + RUN_W'(1);
					job.has_data = 1'b1;
					job.data_bit = evicted;
					ones_run_d   = evicted ? run_inc : '0;
					if (evicted && (run_inc >= RUN_W'(RUN_LIMIT))) begin
						skip_next_d = 1'b1;
						ones_run_d  = '0;
					end
				end
			end else begin
				rx_position_d = rx_position_q + POS_W'(1);
			end
			if (frame_last) begin
				job.marker    = 1'b1;
				ones_run_d    = '0;
				in_frame_d    = 1'b0;
				rx_window_d   = '0;
				rx_position_d = '0;
				skip_next_d   = 1'b0;
			end
		end
	end

	assign push     = accept && (job.has_data || job.marker);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_run_q    <= '0;
			in_frame_q    <= 1'b0;
			rx_window_q   <= '0;
			rx_position_q <= '0;
			skip_next_q   <= 1'b0;
		end else if (mode_wr) begin
			ones_run_q    <= '0;
			in_frame_q    <= 1'b0;
			rx_window_q   <= '0;
			rx_position_q <= '0;
			skip_next_q   <= 1'b0;
		end else if (accept) begin
			ones_run_q    <= ones_run_d;
			in_frame_q    <= in_frame_d;
			rx_window_q   <= rx_window_d;
			rx_position_q <= rx_position_d;
			skip_next_q   <= skip_next_d;
		end
	end

endmodule

>>> hdl/hbsf_queue.sv
`timescale 1ns / 1ps
// Small job queue between the front end and the bit sequencer.
module hbsf_queue #(
	parameter int DEPTH = hbsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hbsf_pkg::job_t push_job,
	input  logic           pop,
	output hbsf_pkg::job_t head,
	output logic           not_empty,
	output logic           full
);
	import hbsf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/hbsf_back.sv
`timescale 1ns / 1ps
// Back end: expands one job at a time into serial results behind an output register.
module hbsf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hbsf_pkg::FLAG_BITS-1:0] flag_pattern,
	input  hbsf_pkg::job_t                 head,
	input  logic                           head_valid,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           out_bit,
	output logic                           bit_valid,
	output logic                           frame_end,
	output logic                           run_end
);
	import hbsf_pkg::*;

	localparam logic [FLAG_IDX_W-1:0] IDX_LAST = FLAG_IDX_W'(FLAG_BITS - 1);

	logic                  cur_valid_q;
	job_t                  cur_q;
	logic [FLAG_IDX_W-1:0] idx_q;

	job_t                  cur_d;
	logic [FLAG_IDX_W-1:0] idx_d;
	logic                  emit_bit;
	logic                  emit_valid;
	logic                  emit_fend;
	logic                  done;
	logic                  can_emit;
	logic                  flag_bit;

	logic                  out_valid_q;
	logic                  out_bit_q;
	logic                  bit_valid_q;
	logic                  frame_end_q;
	logic                  run_end_q;

	assign flag_bit = flag_pattern[IDX_LAST - idx_q];

	// Pick the first outstanding piece of the current job in emission order.
	always_comb begin
		cur_d      = cur_q;
		idx_d      = idx_q;
		emit_bit   = 1'b0;
		emit_valid = 1'b1;
		emit_fend  = 1'b0;
		if (cur_q.open_flag) begin
			emit_bit = flag_bit;
			if (idx_q == IDX_LAST) begin
				cur_d.open_flag = 1'b0;
				idx_d           = '0;
			end else begin
				idx_d = idx_q + FLAG_IDX_W'(1);
			end
		end else if (cur_q.has_data) begin
			emit_bit       = cur_q.data_bit;
			cur_d.has_data = 1'b0;
		end else if (cur_q.stuff_zero) begin
			cur_d.stuff_zero = 1'b0;
		end else if (cur_q.close_flag) begin
			emit_bit = flag_bit;
			if (idx_q == IDX_LAST) begin
				emit_fend        = 1'b1;
				cur_d.close_flag = 1'b0;
				idx_d            = '0;
			end else begin
				idx_d = idx_q + FLAG_IDX_W'(1);
			end
		end else begin
			emit_valid   = 1'b0;
			emit_fend    = 1'b1;
			cur_d.marker = 1'b0;
		end
		done = !(cur_d.open_flag || cur_d.has_data || cur_d.stuff_zero ||
			cur_d.close_flag || cur_d.marker);
	end

	assign can_emit = cur_valid_q && (!out_valid_q || !out_stall);
	assign pop      = head_valid && (!cur_valid_q || (can_emit && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (can_emit) begin
				cur_valid_q <= !done;
				idx_q       <= idx_d;
			end
			if (can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (can_emit) begin
			cur_q <= cur_d;
		end
		if (can_emit) begin
			out_bit_q   <= emit_bit;
			bit_valid_q <= emit_valid;
			frame_end_q <= emit_fend;
			run_end_q   <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bit   = out_bit_q;
	assign bit_valid = bit_valid_q;
	assign frame_end = frame_end_q;
	assign run_end   = run_end_q;

endmodule

>>> hdl/hdlc_bit_stuff_framer.sv
`timescale 1ns / 1ps
// Top level of the HDLC bit stuffing framer and deframer.
// Throughput: the input side takes one item per cycle while the job queue has room; the
// result side delivers one result per cycle while out_stall is low.
// Reset: arst_n clears mode to stuffing, the flag to 0x7E, all frame state, the queue and
// the output valid flag; no clearing pass is needed.
module hdlc_bit_stuff_framer #(
	parameter int RUN_LIMIT   = hbsf_pkg::RUN_LIMIT_DEF,
	parameter int QUEUE_DEPTH = hbsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [hbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbsf_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            in_bit,
	input  logic                            frame_last,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            out_bit,
	output logic                            bit_valid,
	output logic                            frame_end,
	output logic                            run_end
);
	import hbsf_pkg::*;

	// Configuration registers. Writing mode also clears all frame state in the front end.
	logic                 mode_q;
	logic [FLAG_BITS-1:0] flag_q;
	logic                 mode_wr;

	assign mode_wr = cfg_we && (cfg_index == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STUFF;
			flag_q <= FLAG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_FLAG: flag_q <= cfg_data[FLAG_BITS-1:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// The front end classifies each transaction into a job; the queue lets the
	// input keep flowing while the back end serializes flags and stuffed zeros.
	logic accept;
	logic push;
	job_t push_job;
	job_t head;
	logic head_valid;
	logic pop;
	logic q_full;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	hbsf_front #(
		.RUN_LIMIT (RUN_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.mode_wr    (mode_wr),
		.accept     (accept),
		.in_bit     (in_bit),
		.frame_last (frame_last),
		.push       (push),
		.push_job   (push_job)
	);

	hbsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (q_full)
	);

	// The back end reads the flag register at the time each flag bit goes out.
	hbsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.flag_pattern (flag_q),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_bit      (out_bit),
		.bit_valid    (bit_valid),
		.frame_end    (frame_end),
		.run_end      (run_end)
	);

	// A job is never written into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

	// The result that closes a frame is always the last one of its transaction.
	a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> run_end)
		else $error("frame end not on the last result of a transaction");

	// A result without a bit is only the frame end marker, and it carries a zero.
	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bit_valid) |-> (frame_end && !out_bit))
		else $error("malformed marker result");

endmodule
